// ===== sv/itpd_pkg.sv =====
`default_nettype none

package itpd_pkg;

  // ascii codes of the emitted characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // field width port and digit count widths
  localparam int unsigned WIDTH_W   = 7;
  localparam int unsigned DIG_CNT_W = 5;

  // log10(2) as a fraction, for sizing the bcd register
  localparam int unsigned LOG10_2_NUM = 30103;
  localparam int unsigned LOG10_2_DEN = 100000;

  // start of one conversion, sent to the character sequencer
  typedef struct packed {
    logic               go;
    logic               neg;
    logic [WIDTH_W-1:0] width;
  } itpd_start_t;

  // converter status seen by the character sequencer
  typedef struct packed {
    logic                 done;
    logic [DIG_CNT_W-1:0] cnt;
    logic [3:0]           top;
  } itpd_stat_t;

endpackage

`default_nettype wire

// ===== sv/itpd_dabble.sv =====
`default_nettype none

module itpd_dabble #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned NDIG       = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [VALUE_BITS-1:0]   mag_i,
  input  logic                    pop_i,
  output itpd_pkg::itpd_stat_t    stat_o
);
  import itpd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_CONV  = 4'b0010,
    PH_STRIP = 4'b0100,
    PH_HOLD  = 4'b1000
  } phase_e;

  localparam int unsigned BitCntW = $clog2(VALUE_BITS);

  phase_e               phase_q, phase_d;
  logic [BitCntW-1:0]   bitcnt_q, bitcnt_d;
  logic [DIG_CNT_W-1:0] cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [3:0]           bcd_q [NDIG];
  logic [3:0]           bcd_d [NDIG];
  logic [3:0]           adj   [NDIG];
  logic [3:0]           dab   [NDIG];
  logic [3:0]           up    [NDIG];

  // add-3 correction and one-bit shift, magnitude msb enters at the bottom
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
    dab[0] = {adj[0][2:0], mag_q[VALUE_BITS-1]};
    up[0]  = 4'd0;
    for (int i = 1; i < NDIG; i++) begin
      dab[i] = {adj[i][2:0], adj[i-1][3]};
      up[i]  = bcd_q[i-1];
    end
  end

  // phase sequencing: convert, strip leading zeros, then hand out digits
  always_comb begin
    phase_d  = phase_q;
    bitcnt_d = bitcnt_q;
    cnt_d    = cnt_q;
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    if (start_i) begin
      phase_d  = PH_CONV;
      bitcnt_d = BitCntW'(VALUE_BITS - 1);
      mag_d    = mag_i;
      for (int i = 0; i < NDIG; i++) begin
        bcd_d[i] = 4'd0;
      end
    end else begin
      unique case (phase_q)
        PH_CONV: begin
          bcd_d    = dab;
          mag_d    = {mag_q[VALUE_BITS-2:0], 1'b0};
          bitcnt_d = bitcnt_q - BitCntW'(1);
          if (bitcnt_q == '0) begin
            phase_d = PH_STRIP;
            cnt_d   = DIG_CNT_W'(NDIG);
          end
        end
        PH_STRIP: begin
          if (bcd_q[NDIG-1] == 4'd0 && cnt_q > DIG_CNT_W'(1)) begin
            bcd_d = up;
            cnt_d = cnt_q - DIG_CNT_W'(1);
          end else begin
            phase_d = PH_HOLD;
          end
        end
        PH_HOLD: begin
          if (pop_i) begin
            bcd_d = up;
            cnt_d = cnt_q - DIG_CNT_W'(1);
          end
        end
        PH_IDLE: begin
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bitcnt_q <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      bitcnt_q <= bitcnt_d;
      cnt_q    <= cnt_d;
    end
  end

  // magnitude and bcd shift registers
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.done = (phase_q == PH_HOLD);
  assign stat_o.cnt  = cnt_q;
  assign stat_o.top  = bcd_q[NDIG-1];

endmodule

`default_nettype wire

// ===== sv/itpd_emit.sv =====
`default_nettype none

module itpd_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itpd_pkg::itpd_start_t start_i,
  input  itpd_pkg::itpd_stat_t  stat_i,
  output logic                  pop_o,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            char_out_o,
  output logic                  last_o
);
  import itpd_pkg::*;

  typedef enum logic [4:0] {
    EM_IDLE  = 5'b00001,
    EM_WAIT  = 5'b00010,
    EM_PAD   = 5'b00100,
    EM_SIGN  = 5'b01000,
    EM_DIGIT = 5'b10000
  } em_state_e;

  em_state_e          state_q, state_d;
  logic               neg_q, neg_d;
  logic [WIDTH_W-1:0] width_q, width_d;
  logic [WIDTH_W-1:0] pad_q, pad_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         char_q, char_d;
  logic               last_q, last_d;
  logic               adv;
  logic               load;
  logic [WIDTH_W-1:0] len;

  // output register free or being drained this cycle
  assign adv = !out_valid_q || !out_stall_i;
  // text length: sign plus significant digits
  assign len = WIDTH_W'(stat_i.cnt) + WIDTH_W'(neg_q);

  // character sequencer: pad, sign, digits
  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    width_d = width_q;
    pad_d   = pad_q;
    load    = 1'b0;
    char_d  = char_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    unique case (state_q)
      EM_IDLE: begin
        if (start_i.go) begin
          state_d = EM_WAIT;
          neg_d   = start_i.neg;
          width_d = start_i.width;
        end
      end
      EM_WAIT: begin
        if (stat_i.done) begin
          if (width_q > len) begin
            pad_d   = width_q - len;
            state_d = EM_PAD;
          end else begin
            pad_d   = '0;
            state_d = neg_q ? EM_SIGN : EM_DIGIT;
          end
        end
      end
      EM_PAD: begin
        if (adv) begin
          load   = 1'b1;
          char_d = CH_SPACE;
          last_d = 1'b0;
          pad_d  = pad_q - WIDTH_W'(1);
          if (pad_q == WIDTH_W'(1)) begin
            state_d = neg_q ? EM_SIGN : EM_DIGIT;
          end
        end
      end
      EM_SIGN: begin
        if (adv) begin
          load    = 1'b1;
          char_d  = CH_MINUS;
          last_d  = 1'b0;
          state_d = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (adv) begin
          load   = 1'b1;
          pop_o  = 1'b1;
          char_d = CH_ZERO + {4'd0, stat_i.top};
          last_d = (stat_i.cnt == DIG_CNT_W'(1));
          if (stat_i.cnt == DIG_CNT_W'(1)) begin
            state_d = EM_IDLE;
          end
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase
  end

  // output beat register
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EM_IDLE;
      neg_q       <= 1'b0;
      width_q     <= '0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      width_q     <= width_d;
      pad_q       <= pad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != EM_IDLE);
  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== sv/int_to_padded_decimal_text_core.sv =====
// Sequence: after a beat is accepted, the bcd shift loop converts the magnitude, the leading
//   zero bcd digits are stripped, and the first character then enters the output register.
// Throughput: a new beat is taken only once all max(text length, min(min_width, MAX_FIELD))
//   characters of the last one are loaded, set by the one-bit-per-cycle bcd shift loop and then
//   one character per cycle while the output does not stall.
// Reset: asynchronous active low, clears the sequencers and the output valid; no clearing pass.
`default_nettype none

module int_to_padded_decimal_text_core #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_FIELD  = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  input  logic [itpd_pkg::WIDTH_W-1:0]  min_width_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    char_out_o,
  output logic                          last_o
);
  import itpd_pkg::*;

  // decimal digits of 2^(VALUE_BITS-1)
  localparam int unsigned NDIG = ((VALUE_BITS - 1) * LOG10_2_NUM) / LOG10_2_DEN + 1;

  logic                  busy;
  logic                  in_acc;
  logic                  neg;
  logic [VALUE_BITS-1:0] val_u;
  logic [VALUE_BITS-1:0] mag;
  itpd_start_t           start;
  itpd_stat_t            stat;
  logic                  pop;

  assign in_acc     = in_valid_i && !busy;
  assign in_stall_o = busy;

  // sign and unsigned magnitude of the incoming beat
  assign val_u = $unsigned(value_i);
  assign neg   = val_u[VALUE_BITS-1];
  assign mag   = neg ? (~val_u + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : val_u;

  // field width saturated to the largest field
  assign start.go    = in_acc;
  assign start.neg   = neg;
  assign start.width = (min_width_i > WIDTH_W'(MAX_FIELD)) ? WIDTH_W'(MAX_FIELD) : min_width_i;

  itpd_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .mag_i   (mag),
    .pop_i   (pop),
    .stat_o  (stat)
  );

  itpd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .stat_i      (stat),
    .pop_o       (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .last_o      (last_o)
  );

  // an accepted beat keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> in_stall_o)
    else $error("block not busy after accepting a beat");

  // the last character of a run is always a digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (char_out_o >= CH_ZERO && char_out_o <= (CH_ZERO + 8'd9)))
    else $error("last character is not a digit");

  // when idle, a waiting output beat must close its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_stall_o) |-> last_o)
    else $error("idle with an unfinished run in the output register");

  // digits are only popped once conversion is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> stat.done)
    else $error("digit popped before conversion finished");

endmodule

`default_nettype wire
